// ----- rtl/assert_macros.svh -----
// Shared assertion macros, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/qts_pkg.sv -----
package qts_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_byte_valid;
    logic       term_done;
    logic       text_done;
    logic       run_last;
  } out_item_t;

  // quote span codes
  localparam logic [1:0] QkNone   = 2'd0;
  localparam logic [1:0] QkSingle = 2'd1;
  localparam logic [1:0] QkDouble = 2'd2;

  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChR      = 8'h72;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChLf) || (b == ChVt) ||
           (b == ChFf) || (b == ChCr);
  endfunction

  function automatic logic [1:0] quote_code(input logic [7:0] b);
    if (b == ChSquote) return QkSingle;
    if (b == ChDquote) return QkDouble;
    return QkNone;
  endfunction

endpackage

// ----- rtl/quoted_term_splitter.sv -----
// Channel | Ports                          | Moves
// --------+--------------------------------+------------------------------------
// input   | in_valid, in_ready, in_data    | one text byte and/or end marker
// output  | out_valid, out_ready, out_data | one decoded byte / term / text mark
//
// Each input transaction is decoded in the cycle it is accepted; its 0..2
// results load a two-deep result register (head + spare) that feeds the output.
// Back to back at 1 transaction/cycle while out_ready is high; an escaped
// ordinary byte gives two results and holds in_ready low while the spare drains.
// Reset (rst_n, synchronous): clears quote, escape and term state and both valids.
// in_ready = spare empty and (head empty or out_ready): a stalled head blocks input.
`include "assert_macros.svh"

module quoted_term_splitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qts_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qts_pkg::out_item_t out_data
);
  import qts_pkg::*;

  // tokenizer state
  logic [1:0] quote_kind_r, quote_kind_nxt;
  logic       escape_pending_r, escape_pending_nxt;
  logic       term_has_bytes_r, term_has_bytes_nxt;

  // result register: head feeds the port, spare holds a second result
  out_item_t  head_r, spare_r;
  logic       head_valid_r, spare_valid_r;

  // decode outputs
  out_item_t  res0, res1;
  logic [1:0] res_cnt;
  logic       in_span;

  logic in_fire, out_fire;

  assign in_ready  = !spare_valid_r && (!head_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = head_valid_r && out_ready;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

  assign in_span = (quote_kind_r == QkSingle) || (quote_kind_r == QkDouble);

  // One-pass decode of the current transaction.
  always_comb begin
    quote_kind_nxt     = quote_kind_r;
    escape_pending_nxt = escape_pending_r;
    term_has_bytes_nxt = term_has_bytes_r;
    res0    = '0;
    res1    = '0;
    res_cnt = 2'd0;

    if (in_data.byte_present) begin
      if (!in_span) begin
        if (is_ws(in_data.text_byte)) begin
          // whitespace closes a term only if it had bytes
          if (term_has_bytes_r) begin
            res0.term_done     = 1'b1;
            res_cnt            = 2'd1;
            term_has_bytes_nxt = 1'b0;
          end
        end else if (quote_code(in_data.text_byte) != QkNone) begin
          quote_kind_nxt = quote_code(in_data.text_byte);
        end else begin
          res0.out_byte       = in_data.text_byte;
          res0.out_byte_valid = 1'b1;
          res_cnt             = 2'd1;
          term_has_bytes_nxt  = 1'b1;
        end
      end else if (escape_pending_r) begin
        escape_pending_nxt  = 1'b0;
        term_has_bytes_nxt  = 1'b1;
        res0.out_byte_valid = 1'b1;
        res_cnt             = 2'd1;
        case (in_data.text_byte)
          ChN:                        res0.out_byte = ChLf;
          ChT:                        res0.out_byte = ChTab;
          ChR:                        res0.out_byte = ChCr;
          ChBslash, ChSquote, ChDquote: res0.out_byte = in_data.text_byte;
          default: begin
            // unknown escape keeps its backslash
            res0.out_byte       = ChBslash;
            res1.out_byte       = in_data.text_byte;
            res1.out_byte_valid = 1'b1;
            res_cnt             = 2'd2;
          end
        endcase
      end else if (in_data.text_byte == ChBslash) begin
        escape_pending_nxt = 1'b1;
      end else if (quote_code(in_data.text_byte) == quote_kind_r) begin
        quote_kind_nxt = QkNone;
      end else begin
        res0.out_byte       = in_data.text_byte;
        res0.out_byte_valid = 1'b1;
        res_cnt             = 2'd1;
        term_has_bytes_nxt  = 1'b1;
      end
    end

    if (in_data.end_of_text) begin
      // dangling escape: only reachable with no result so far
      if (escape_pending_nxt) begin
        res0.out_byte       = ChBslash;
        res0.out_byte_valid = 1'b1;
        res_cnt             = 2'd1;
        term_has_bytes_nxt  = 1'b1;
      end
      if (res_cnt == 2'd0) begin
        res_cnt = 2'd1;
      end
      // a term mark already set by whitespace stays set
      if (res_cnt == 2'd2) begin
        res1.term_done = res1.term_done || term_has_bytes_nxt;
        res1.text_done = 1'b1;
      end else begin
        res0.term_done = res0.term_done || term_has_bytes_nxt;
        res0.text_done = 1'b1;
      end
      quote_kind_nxt     = QkNone;
      escape_pending_nxt = 1'b0;
      term_has_bytes_nxt = 1'b0;
    end

    if (res_cnt == 2'd2) begin
      res1.run_last = 1'b1;
    end else begin
      res0.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_kind_r     <= QkNone;
      escape_pending_r <= 1'b0;
      term_has_bytes_r <= 1'b0;
    end else if (in_fire) begin
      quote_kind_r     <= quote_kind_nxt;
      escape_pending_r <= escape_pending_nxt;
      term_has_bytes_r <= term_has_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r  <= 1'b0;
      spare_valid_r <= 1'b0;
    end else if (in_fire && (res_cnt != 2'd0)) begin
      head_valid_r  <= 1'b1;
      spare_valid_r <= (res_cnt == 2'd2);
    end else if (out_fire) begin
      head_valid_r  <= spare_valid_r;
      spare_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (res_cnt != 2'd0)) begin
      head_r  <= res0;
      spare_r <= res1;
    end else if (out_fire) begin
      head_r  <= spare_r;
    end
  end

  // spare never holds a result without the head in front of it
  `AST_IMPLY(a_spare_behind_head, spare_valid_r, head_valid_r)
  // a head result that is not the item's last must have its follower waiting
  `AST_IMPLY(a_run_tail_waits, head_valid_r && !head_r.run_last, spare_valid_r)
  // escape flag only lives inside a quoted span
  `AST_IMPLY(a_escape_in_span, escape_pending_r,
             (quote_kind_r == QkSingle) || (quote_kind_r == QkDouble))
  // end of text leaves the tokenizer clean
  `AST_NEXT(a_end_clears, in_fire && in_data.end_of_text,
            (quote_kind_r == QkNone) && !escape_pending_r && !term_has_bytes_r)

endmodule

// ----- bench/quoted_term_splitter_tb.sv -----
`timescale 1ns / 100ps

module quoted_term_splitter_tb;
  import qts_pkg::*;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Predicted results, oldest first, and the splitter state the
  // prediction keeps on its own side.
  out_item_t  decoded_q [$];
  logic [1:0] span_kind = QkNone;
  bit         escape_live = 1'b0;
  bit         term_live = 1'b0;

  int fail_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int burst_left = 0;

  // Receiver stall pattern state.
  int       rx_mode = 0;
  int       rx_mode_left = 0;
  bit [3:0] rx_tick = '0;

  quoted_term_splitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------
  // Space plus TAB, LF, VT, FF, CR (the 0x09..0x0D range).
  function automatic bit is_blank(input logic [7:0] b);
    return (b == ChSpace) || (b >= ChTab && b <= ChCr);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor: decodes one accepted input transaction into 0..2 results
  // and appends them to decoded_q.
  // ---------------------------------------------------------------------
  function automatic void decode_item(input in_item_t it);
    logic [7:0] found [$];
    out_item_t  res [$];
    out_item_t  r;
    logic [7:0] b;
    bit         close_term;
    b = it.text_byte;
    close_term = 1'b0;
    if (it.byte_present) begin
      if (span_kind != QkSingle && span_kind != QkDouble) begin
        // outside a span; code three counts as no span
        if (is_blank(b)) begin
          if (term_live) begin
            close_term = 1'b1;
            term_live = 1'b0;
          end
        end else if (b == ChSquote) begin
          span_kind = QkSingle;
        end else if (b == ChDquote) begin
          span_kind = QkDouble;
        end else begin
          found = {found, b};
        end
      end else if (escape_live) begin
        escape_live = 1'b0;
        case (b)
          ChN: found = {found, ChLf};
          ChT: found = {found, ChTab};
          ChR: found = {found, ChCr};
          ChBslash, ChSquote, ChDquote: found = {found, b};
          default: begin
            // unknown escape keeps its backslash
            found = {found, ChBslash};
            found = {found, b};
          end
        endcase
      end else if (b == ChBslash) begin
        escape_live = 1'b1;
      end else if ((b == ChSquote && span_kind == QkSingle) ||
                   (b == ChDquote && span_kind == QkDouble)) begin
        span_kind = QkNone;
      end else begin
        found = {found, b};
      end
    end
    // dangling escape at end of text turns into a plain backslash
    if (it.end_of_text && escape_live) found = {found, ChBslash};
    if (found.size() != 0) term_live = 1'b1;
    foreach (found[i]) begin
      r = '0;
      r.out_byte = found[i];
      r.out_byte_valid = 1'b1;
      res = {res, r};
    end
    if (close_term) begin
      r = '0;
      r.term_done = 1'b1;
      res = {res, r};
    end
    if (it.end_of_text) begin
      if (res.size() == 0) begin
        r = '0;
        res = {res, r};
      end
      if (term_live) res[res.size() - 1].term_done = 1'b1;
      res[res.size() - 1].text_done = 1'b1;
      span_kind = QkNone;
      escape_live = 1'b0;
      term_live = 1'b0;
    end
    if (res.size() != 0) res[res.size() - 1].run_last = 1'b1;
    foreach (res[i]) decoded_q = {decoded_q, res[i]};
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] error: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                results_seen, name, got, want));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with none predicted (0x%0h)",
                                results_seen, got));
    end else begin
      want = decoded_q.pop_front();
      check_field("out_byte", got.out_byte, want.out_byte);
      check_field("out_byte_valid", got.out_byte_valid, want.out_byte_valid);
      check_field("term_done", got.term_done, want.term_done);
      check_field("text_done", got.text_done, want.text_done);
      check_field("run_last", got.run_last, want.run_last);
    end
    results_seen++;
  endtask

  // Both channels sampled at the edge, before this edge's updates land.
  // Input side goes first so a prediction is always in place in time.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) decode_item(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: cycles through free-running, random, periodic and long
  // stall modes, each held for a random stretch.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rx_tick <= rx_tick + 4'd1;
    if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(32, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) > 2);
      2: out_ready <= (rx_tick[1:0] != 2'b11);
      default: out_ready <= (rx_tick > 4'd9);
    endcase
  end

  // ---------------------------------------------------------------------
  // Sender. Called at a clock edge; inside a burst it returns at the edge
  // the transaction is taken and valid stays high for the next call; at the
  // end of a burst valid drops for a random gap before it returns.
  // ---------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(6, 20)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit present, input bit last);
    in_item_t it;
    it.text_byte = b;
    it.byte_present = present;
    it.end_of_text = last;
    send_item(it);
  endtask

  task automatic send_str(input string s, input bit last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], 1'b1, last && (i == s.len() - 1));
  endtask

  // Park the sender until every predicted result is out, then let the
  // pipeline settle.
  task automatic wait_all_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Random pickers
  // ---------------------------------------------------------------------
  function automatic logic [7:0] pick_blank;
    case ($urandom_range(0, 5))
      0: return ChSpace;
      1: return ChTab;
      2: return ChLf;
      3: return ChVt;
      4: return ChFf;
      default: return ChCr;
    endcase
  endfunction

  // any byte that is neither blank nor a quote mark
  function automatic logic [7:0] pick_plain;
    logic [7:0] b;
    do b = 8'($urandom); while (is_blank(b) || b == ChSquote || b == ChDquote);
    return b;
  endfunction

  function automatic logic [7:0] pick_escaped;
    case ($urandom_range(0, 7))
      0: return ChN;
      1: return ChT;
      2: return ChR;
      3: return ChBslash;
      4: return ChSquote;
      5: return ChDquote;
      default: return 8'($urandom);
    endcase
  endfunction

  // span body byte: anything but backslash and the closing mark
  function automatic logic [7:0] pick_span_byte(input logic [7:0] q);
    logic [7:0] b;
    do b = 8'($urandom); while (b == ChBslash || b == q);
    return b;
  endfunction

  // ---------------------------------------------------------------------
  // Well-formed text: terms made of plain runs, quoted spans with escapes
  // and empty spans, split by blank runs, closed in one of several ways.
  // ---------------------------------------------------------------------
  task automatic send_random_text;
    int         nterms;
    int         npieces;
    int         nbody;
    logic [7:0] q;
    nterms = $urandom_range(1, 4);
    for (int k = 0; k < nterms; k++) begin
      repeat ($urandom_range(0, 2)) send_byte(pick_blank(), 1'b1, 1'b0);
      npieces = $urandom_range(1, 3);
      for (int j = 0; j < npieces; j++) begin
        case ($urandom_range(0, 4))
          0, 1: repeat ($urandom_range(1, 4)) send_byte(pick_plain(), 1'b1, 1'b0);
          2, 3: begin
            q = $urandom_range(0, 1) ? ChSquote : ChDquote;
            send_byte(q, 1'b1, 1'b0);
            nbody = $urandom_range(0, 5);
            for (int m = 0; m < nbody; m++) begin
              if ($urandom_range(0, 2) == 0) begin
                send_byte(ChBslash, 1'b1, 1'b0);
                send_byte(pick_escaped(), 1'b1, 1'b0);
              end else begin
                send_byte(pick_span_byte(q), 1'b1, 1'b0);
              end
            end
            // now and then the span is left open
            if ($urandom_range(0, 9) != 0) send_byte(q, 1'b1, 1'b0);
          end
          default: begin
            q = $urandom_range(0, 1) ? ChSquote : ChDquote;
            send_byte(q, 1'b1, 1'b0);
            send_byte(q, 1'b1, 1'b0);
          end
        endcase
      end
      if (k != nterms - 1) repeat ($urandom_range(1, 2)) send_byte(pick_blank(), 1'b1, 1'b0);
    end
    case ($urandom_range(0, 3))
      0: send_byte(8'($urandom), 1'b0, 1'b1);        // bare end marker
      1: send_byte(pick_plain(), 1'b1, 1'b1);        // end on a byte
      2: send_byte(pick_blank(), 1'b1, 1'b1);        // end on a blank
      default: begin                                 // end on a dangling escape
        send_byte(ChDquote, 1'b1, 1'b0);
        send_byte(ChBslash, 1'b1, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed_cases;
    // backslash outside a span, the other quote inside a span, an unknown
    // escape, every known escape, then the closing quote
    send_str("\\'x\"\\q\\n\\t\\r\\\\\\'\\\"'", 1'b0);
    send_byte(ChSpace, 1'b1, 1'b0);     // closes the term
    send_byte(ChVt, 1'b1, 1'b0);        // empty term, nothing out
    send_str("''", 1'b0);               // empty span adds no bytes
    send_byte(ChCr, 1'b1, 1'b0);        // still an empty term
    send_byte(8'hA5, 1'b0, 1'b0);       // neither byte nor end
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(ChFf, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);       // byte that also ends the text
    send_byte(8'h00, 1'b0, 1'b1);       // end of an empty text
    send_byte(ChDquote, 1'b1, 1'b0);
    send_byte(ChBslash, 1'b1, 1'b1);    // unclosed span, dangling escape
    wait_all_results();
  endtask

  task automatic test_wellformed_text;
    int texts;
    texts = 0;
    while (items_sent < 330) begin
      send_random_text();
      texts++;
      // full drain now and then
      if (texts % 8 == 0) wait_all_results();
    end
    wait_all_results();
  endtask

  task automatic test_random_noise;
    in_item_t it;
    while (items_sent < 450) begin
      it.text_byte = ($urandom_range(0, 2) == 0) ? pick_escaped() : 8'($urandom);
      if ($urandom_range(0, 4) == 0) it.text_byte = pick_blank();
      it.byte_present = ($urandom_range(0, 6) != 0);
      it.end_of_text = ($urandom_range(0, 11) == 0);
      send_item(it);
    end
    send_byte(8'h00, 1'b0, 1'b1);
    wait_all_results();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_wellformed_text();
    test_random_noise();
    wait_all_results();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
